// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They are empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/core/sadl_pkg.sv =====
// ----------------------------------------------------------------------------
// sadl_pkg
// Types and constants shared by the slot allocator and its free stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sadl_pkg;

  // Slot space and field widths
  localparam int SLOTS  = 256;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 9;
  localparam int UPD_W  = 16;
  localparam logic [UPD_W-1:0] UPD_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_MOVE
  } state_t;

  // Request to the free-slot stack
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] data;
  } lifo_req_t;

endpackage

// ===== rtl/core/sadl_lifo.sv =====
// ----------------------------------------------------------------------------
// sadl_lifo
// LIFO stack of freed slots: one memory, a depth counter, registered pop data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sadl_lifo
  import sadl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lifo_req_t         req,
  output logic [SLOT_W-1:0] pop_data,
  output logic [CNT_W-1:0]  depth
);

  logic [SLOT_W-1:0] mem [SLOTS];
  logic [SLOT_W-1:0] top_idx;

  assign top_idx = depth[SLOT_W-1:0] - SLOT_W'(1);

  // Write on push at the current depth
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[depth[SLOT_W-1:0]] <= req.data;
    end
  end

  // Read the top entry on pop
  always_ff @(posedge clk) begin
    if (req.pop) begin
      pop_data <= mem[top_idx];
    end
  end

  // Track the stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (req.push) begin
      depth <= depth + CNT_W'(1);
    end else if (req.pop) begin
      depth <= depth - CNT_W'(1);
    end
  end

  `ASSERT_NEVER(a_no_pop_empty, clk, rst, req.pop && depth == '0, "pop from empty free stack")
  `ASSERT_NEVER(a_no_push_full, clk, rst, req.push && depth == CNT_W'(SLOTS), "push to full stack")
  `ASSERT_NEVER(a_no_push_pop, clk, rst, req.push && req.pop, "push and pop in one cycle")

endmodule

// ===== rtl/core/slot_allocator_dense_list.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_dense_list
// Slot allocator with a LIFO free stack and a packed list of live slots.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with cmd and slot while busy is low; it
//   is taken at that clock edge. busy stays high while the request works.
//   Each request gives one result, shown for exactly one cycle with done
//   high on slot_out, dense_pos, moved, live_count, status, frame_updates.
//   The receiver cannot stall; it must take the result in that cycle.
//   Path from the accepting edge to done:
//     update, tick, add of a never-used slot, failed add: registered at that edge
//     add of a freed slot: through ST_POP (registered read of the free stack)
//     remove: ST_SCAN until the slot is found, then ST_MOVE to move the last
//     entry into its place unless the slot was last; not found scans them all.
//   The remove time is set by the linear scan of the packed list, one entry
//   per cycle through its single read port and the shared slot comparator.
//   A new request may be taken in the cycle in which done is high.
//   Reset empties the free stack and the packed list and clears the update
//   counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slot_allocator_dense_list
  import sadl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        cmd,
  input  logic [SLOT_W-1:0] slot,
  output logic              busy,
  output logic              done,
  output logic [SLOT_W-1:0] slot_out,
  output logic [SLOT_W-1:0] dense_pos,
  output logic              moved,
  output logic [CNT_W-1:0]  live_count,
  output logic [1:0]        status,
  output logic [UPD_W-1:0]  frame_updates
);

  state_t            state, state_next;
  logic              accept;
  cmd_t              cmd_in;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  next_fresh;
  logic [CNT_W-1:0]  packed_count;
  logic [UPD_W-1:0]  update_counter;
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] last_idx;
  logic              hit;
  logic              free_empty, free_full, fresh_left, room, at_last;

  // Free stack link
  lifo_req_t         lreq;
  logic [SLOT_W-1:0] lifo_data;
  logic [CNT_W-1:0]  free_depth;

  // Packed list memory ports
  logic [SLOT_W-1:0] packed_list [SLOTS];
  logic              pk_re, pk_we;
  logic [SLOT_W-1:0] pk_raddr, pk_waddr, pk_wdata, pk_rd_data;

  // Sequencer controls and result values
  logic              cnt_bump, cnt_clear, fresh_inc, pc_inc, pc_dec, scan_adv, scan_clr;
  logic              res_load;
  logic [SLOT_W-1:0] res_slot, res_pos;
  logic              res_moved;
  status_t           res_status;
  logic [UPD_W-1:0]  res_frame;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign cmd_in     = cmd_t'(cmd);
  assign last_idx   = packed_count[SLOT_W-1:0] - SLOT_W'(1);
  assign at_last    = (scan_idx == last_idx);
  assign free_empty = (free_depth == '0);
  assign free_full  = (free_depth == CNT_W'(SLOTS));
  assign fresh_left = (next_fresh < CNT_W'(SLOTS));
  assign room       = (packed_count < CNT_W'(SLOTS));
  assign live_count = packed_count;

  // Shared compare unit: scanned entry against the requested slot
  assign hit = (pk_rd_data == slot_q);

  sadl_lifo u_lifo (
    .clk      (clk),
    .rst      (rst),
    .req      (lreq),
    .pop_data (lifo_data),
    .depth    (free_depth)
  );

  // Packed list: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pk_we) begin
      packed_list[pk_waddr] <= pk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_re) begin
      pk_rd_data <= packed_list[pk_raddr];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_in == CMD_ADD && !free_empty) begin
            state_next = ST_POP;
          end else if (cmd_in == CMD_REMOVE && packed_count != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_POP: state_next = ST_IDLE;
      ST_SCAN: begin
        priority if (hit && !free_full && !at_last) begin
          state_next = ST_MOVE;
        end else if (hit || at_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_MOVE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    lreq       = '0;
    pk_re      = 1'b0;
    pk_raddr   = scan_idx;
    pk_we      = 1'b0;
    pk_waddr   = packed_count[SLOT_W-1:0];
    pk_wdata   = next_fresh[SLOT_W-1:0];
    cnt_bump   = 1'b0;
    cnt_clear  = 1'b0;
    fresh_inc  = 1'b0;
    pc_inc     = 1'b0;
    pc_dec     = 1'b0;
    scan_adv   = 1'b0;
    scan_clr   = 1'b0;
    res_load   = 1'b0;
    res_slot   = slot_q;
    res_pos    = '0;
    res_moved  = 1'b0;
    res_status = STAT_OK;
    res_frame  = '0;
    unique case (state)
      ST_IDLE: begin
        res_slot = slot;
        if (accept) begin
          unique case (cmd_in)
            CMD_ADD: begin
              cnt_bump = 1'b1;
              priority if (!free_empty) begin
                lreq.pop = 1'b1;
              end else if (fresh_left) begin
                fresh_inc = 1'b1;
                res_load  = 1'b1;
                if (room) begin
                  pk_we    = 1'b1;
                  pc_inc   = 1'b1;
                  res_slot = next_fresh[SLOT_W-1:0];
                  res_pos  = packed_count[SLOT_W-1:0];
                end else begin
                  res_status = STAT_FULL;
                end
              end else begin
                res_load   = 1'b1;
                res_status = STAT_FULL;
              end
            end
            CMD_UPDATE: begin
              cnt_bump = 1'b1;
              res_load = 1'b1;
            end
            CMD_REMOVE: begin
              cnt_bump = 1'b1;
              scan_clr = 1'b1;
              if (packed_count == '0) begin
                res_load   = 1'b1;
                res_status = STAT_NOT_LIVE;
              end else begin
                pk_re    = 1'b1;
                pk_raddr = '0;
              end
            end
            CMD_TICK: begin
              cnt_clear = 1'b1;
              res_load  = 1'b1;
              res_frame = update_counter;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        res_load = 1'b1;
        if (room) begin
          pk_we    = 1'b1;
          pk_wdata = lifo_data;
          pc_inc   = 1'b1;
          res_slot = lifo_data;
          res_pos  = packed_count[SLOT_W-1:0];
        end else begin
          res_status = STAT_FULL;
        end
      end
      ST_SCAN: begin
        priority if (hit && !free_full) begin
          lreq.push = 1'b1;
          lreq.data = slot_q;
          if (at_last) begin
            pc_dec   = 1'b1;
            res_load = 1'b1;
            res_pos  = scan_idx;
          end else begin
            pk_re    = 1'b1;
            pk_raddr = last_idx;
          end
        end else if (hit || at_last) begin
          res_load   = 1'b1;
          res_status = STAT_NOT_LIVE;
        end else begin
          pk_re    = 1'b1;
          pk_raddr = scan_idx + SLOT_W'(1);
          scan_adv = 1'b1;
        end
      end
      ST_MOVE: begin
        pk_we     = 1'b1;
        pk_waddr  = scan_idx;
        pk_wdata  = pk_rd_data;
        pc_dec    = 1'b1;
        res_load  = 1'b1;
        res_pos   = scan_idx;
        res_moved = 1'b1;
      end
      default: ;
    endcase
  end

  // Advance state and bookkeeping counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      next_fresh     <= '0;
      packed_count   <= '0;
      update_counter <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (fresh_inc) begin
        next_fresh <= next_fresh + CNT_W'(1);
      end
      if (pc_inc) begin
        packed_count <= packed_count + CNT_W'(1);
      end else if (pc_dec) begin
        packed_count <= packed_count - CNT_W'(1);
      end
      if (cnt_clear) begin
        update_counter <= '0;
      end else if (cnt_bump && update_counter != UPD_MAX) begin
        update_counter <= update_counter + UPD_W'(1);
      end
    end
  end

  // Hold the request slot and the scan position
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q <= slot;
    end
    if (scan_clr) begin
      scan_idx <= '0;
    end else if (scan_adv) begin
      scan_idx <= scan_idx + SLOT_W'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (res_load) begin
      slot_out      <= res_slot;
      dense_pos     <= res_pos;
      moved         <= res_moved;
      status        <= res_status;
      frame_updates <= res_frame;
    end
  end

  `ASSERT_NEVER(a_done_idle, clk, rst, done && busy, "result shown while still busy")
  `ASSERT_NEVER(a_count_max, clk, rst, packed_count > CNT_W'(SLOTS), "packed list overflow")
  `ASSERT_PROP(a_slot_balance, clk, rst, !busy |-> ((10'(packed_count) + 10'(free_depth)) == 10'(next_fresh)), "slot accounting broken")
  `ASSERT_PROP(a_update_quick, clk, rst, (accept && cmd_in == CMD_UPDATE) |=> (done && status == STAT_OK), "update result late")

endmodule
